FILE: rtl/ecah_pkg.sv
// shared types, constants and helpers for the elementary ca history engine
// no dependencies; used by every module of the block by scoped names
`default_nettype none

package ecah_pkg;

	// geometry of the automaton and of the history store
	localparam int CELLS = 64;
	localparam int DEPTH = 256;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int ROW_W = 64;
	localparam logic [8:0] DEPTH_CAP = (DEPTH < 256) ? 9'(DEPTH) : 9'd256;

	// command codes of an input beat
	typedef enum logic [1:0] {
		CMD_RESTART = 2'd0,
		CMD_NEXT    = 2'd1,
		CMD_SEEK    = 2'd2
	} cmd_t;

	// status codes of a result beat
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_LIMIT = 2'd1,
		STAT_RANGE = 2'd2
	} stat_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_RULE   = 2'd0,
		REG_DEPTH  = 2'd1,
		REG_START  = 2'd2,
		REG_CENTER = 2'd3
	} cfg_reg_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;    // latch target of the accepted beat
		logic load_seed;  // load generation zero and store it
		logic rd_en;      // read one history row
		logic rd_next;    // read address: 1 current + 1, 0 target
		logic load_rd;    // take the read row as current
		logic gen;        // compute, store and move to a new generation
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic cur_lt_high;
		logic at_limit;
		logic tgt_out;
		logic tgt_le_high;
		logic cur_lt_tgt;
	} dp_flags_t;

	// history address of a generation number
	function automatic logic [ADDR_W-1:0] gen_addr(logic [7:0] g);
		logic [31:0] wide;
		wide = 32'(g);
		return wide[ADDR_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/elementary_ca_history_engine.sv
// top level of the elementary ca history engine: configuration registers,
// controller and datapath; depends on ecah_pkg, ecah_ctrl and ecah_datapath
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------------
//  command  | start, busy        | command, target_generation
//  result   | done (one cycle)   | current_row, current_index, generated_count,
//           |                    | status
//  config   | cfg_write          | cfg_index, cfg_data
//
// restart, a next that computes, a limit hit and an out of range seek finish
// in the decode state; a next or seek served from the history also passes the
// load state, bound by the registered read of the history memory.
// a seek past the stored generations walks on: a replayed generation takes a
// walk and a load state, a computed one a walk state alone.
// reset sets config defaults, clears row, counters and state, not the history.
// done is high for exactly one cycle per beat; the receiver cannot stall it.
`default_nettype none

module elementary_ca_history_engine (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	input  wire logic [1:0]   command,
	input  wire logic [7:0]   target_generation,
	output logic              done,
	output logic [63:0]       current_row,
	output logic [7:0]        current_index,
	output logic [7:0]        generated_count,
	output logic [1:0]        status,
	input  wire logic         cfg_write,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [63:0]  cfg_data
);

	logic [7:0]           rule_q;
	logic [8:0]           max_depth_q;
	logic [63:0]          start_pattern_q;
	logic                 center_seed_q;
	ecah_pkg::dp_cmd_t    dp_cmd;
	ecah_pkg::dp_flags_t  flags;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q          <= 8'd30;
			max_depth_q     <= 9'd256;
			start_pattern_q <= '0;
			center_seed_q   <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ecah_pkg::REG_RULE:   rule_q          <= cfg_data[7:0];
				ecah_pkg::REG_DEPTH:  max_depth_q     <= cfg_data[8:0];
				ecah_pkg::REG_START:  start_pattern_q <= cfg_data;
				ecah_pkg::REG_CENTER: center_seed_q   <= cfg_data[0];
			endcase
		end
	end

	// sequencing
	ecah_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.flags   (flags),
		.dp_cmd  (dp_cmd),
		.busy    (busy),
		.done    (done),
		.status  (status)
	);

	// row, counters and history
	ecah_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (dp_cmd),
		.target_generation (target_generation),
		.rule_number       (rule_q),
		.max_depth         (max_depth_q),
		.start_pattern     (start_pattern_q),
		.center_seed       (center_seed_q),
		.flags             (flags),
		.current_row       (current_row),
		.current_index     (current_index),
		.generated_count   (generated_count)
	);

endmodule

`default_nettype wire

FILE: rtl/ecah_datapath.sv
// datapath: row register, generation counters, rule evaluation and history memory
// depends on ecah_pkg
`default_nettype none

module ecah_datapath (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire ecah_pkg::dp_cmd_t        cmd,
	input  wire logic [7:0]               target_generation,
	input  wire logic [7:0]               rule_number,
	input  wire logic [8:0]               max_depth,
	input  wire logic [63:0]              start_pattern,
	input  wire logic                     center_seed,
	output ecah_pkg::dp_flags_t           flags,
	output logic [ecah_pkg::ROW_W-1:0]    current_row,
	output logic [7:0]                    current_index,
	output logic [7:0]                    generated_count
);

	logic [ecah_pkg::CELLS-1:0]  row_q;
	logic [7:0]                  cur_q;
	logic [7:0]                  high_q;
	logic [7:0]                  tgt_q;
	logic [ecah_pkg::CELLS-1:0]  hist_q [ecah_pkg::DEPTH];
	logic [ecah_pkg::CELLS-1:0]  rd_data_q;
	logic [7:0]                  rd_gen_q;

	logic [ecah_pkg::CELLS-1:0]  seed_row;
	logic [ecah_pkg::CELLS-1:0]  evolved;
	logic [8:0]                  eff_depth;
	logic [8:0]                  cur_p1;
	logic [7:0]                  rd_gen;
	logic                        wr_en;
	logic [7:0]                  wr_gen;
	logic [ecah_pkg::CELLS-1:0]  wr_data;

	// generation zero row
	always_comb begin
		seed_row = '0;
		if (center_seed) begin
			seed_row[ecah_pkg::CELLS/2] = 1'b1;
		end else begin
			seed_row = start_pattern[ecah_pkg::CELLS-1:0];
		end
	end

	// rule lookup for every cell of the ring
	always_comb begin
		for (int i = 0; i < ecah_pkg::CELLS; i++) begin
			int l;
			int r;
			l = (i == 0) ? ecah_pkg::CELLS - 1 : i - 1;
			r = (i == ecah_pkg::CELLS - 1) ? 0 : i + 1;
			evolved[i] = rule_number[{row_q[l], row_q[i], row_q[r]}];
		end
	end

	// usable history depth
	always_comb begin
		priority if (max_depth == 9'd0) begin
			eff_depth = 9'd1;
		end else if (max_depth > ecah_pkg::DEPTH_CAP) begin
			eff_depth = ecah_pkg::DEPTH_CAP;
		end else begin
			eff_depth = max_depth;
		end
	end

	assign cur_p1 = {1'b0, cur_q} + 9'd1;

	// status toward the controller
	assign flags.cur_lt_high = cur_q < high_q;
	assign flags.at_limit    = cur_p1 >= eff_depth;
	assign flags.tgt_out     = {1'b0, tgt_q} >= eff_depth;
	assign flags.tgt_le_high = tgt_q <= high_q;
	assign flags.cur_lt_tgt  = cur_q < tgt_q;

	// history port selects
	assign rd_gen  = cmd.rd_next ? cur_p1[7:0] : tgt_q;
	assign wr_en   = cmd.load_seed | cmd.gen;
	assign wr_gen  = cmd.gen ? cur_p1[7:0] : 8'd0;
	assign wr_data = cmd.gen ? evolved : seed_row;

	// history memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			hist_q[ecah_pkg::gen_addr(wr_gen)] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= hist_q[ecah_pkg::gen_addr(rd_gen)];
			rd_gen_q  <= rd_gen;
		end
	end

	// target of the beat in flight
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tgt_q <= target_generation;
		end
	end

	// current row and generation counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			cur_q  <= '0;
			high_q <= '0;
		end else begin
			if (cmd.load_seed) begin
				row_q  <= seed_row;
				cur_q  <= '0;
				high_q <= '0;
			end else if (cmd.load_rd) begin
				row_q <= rd_data_q;
				cur_q <= rd_gen_q;
			end else if (cmd.gen) begin
				row_q  <= evolved;
				cur_q  <= cur_p1[7:0];
				high_q <= cur_p1[7:0];
			end
		end
	end

	assign current_row     = ecah_pkg::ROW_W'(row_q);
	assign current_index   = cur_q;
	assign generated_count = high_q;

endmodule

`default_nettype wire

FILE: rtl/ecah_ctrl.sv
// controller: decodes a command beat and sequences reads, steps and the result strobe
// depends on ecah_pkg
`default_nettype none

module ecah_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [1:0]           command,
	input  wire ecah_pkg::dp_flags_t  flags,
	output ecah_pkg::dp_cmd_t         dp_cmd,
	output logic                      busy,
	output logic                      done,
	output logic [1:0]                status
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECODE,
		S_WALK,
		S_LOAD
	} state_t;

	state_t           state_q;
	logic [1:0]       cmd_q;
	logic             walk_q;
	logic             busy_q;
	logic             done_q;
	ecah_pkg::stat_t  status_q;

	// datapath commands per state
	always_comb begin
		dp_cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				dp_cmd.capture = start & ~busy_q;
			end
			S_DECODE: begin
				case (cmd_q)
					ecah_pkg::CMD_RESTART: begin
						dp_cmd.load_seed = 1'b1;
					end
					ecah_pkg::CMD_NEXT: begin
						if (flags.cur_lt_high) begin
							dp_cmd.rd_en   = 1'b1;
							dp_cmd.rd_next = 1'b1;
						end else if (!flags.at_limit) begin
							dp_cmd.gen = 1'b1;
						end
					end
					ecah_pkg::CMD_SEEK: begin
						if (!flags.tgt_out && flags.tgt_le_high) begin
							dp_cmd.rd_en = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			S_WALK: begin
				if (flags.cur_lt_tgt) begin
					if (flags.cur_lt_high) begin
						dp_cmd.rd_en   = 1'b1;
						dp_cmd.rd_next = 1'b1;
					end else begin
						dp_cmd.gen = 1'b1;
					end
				end
			end
			S_LOAD: begin
				dp_cmd.load_rd = 1'b1;
			end
		endcase
	end

	// state, status and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cmd_q    <= '0;
			walk_q   <= 1'b0;
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			status_q <= ecah_pkg::STAT_OK;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start && !busy_q) begin
						cmd_q    <= command;
						busy_q   <= 1'b1;
						status_q <= ecah_pkg::STAT_OK;
						state_q  <= S_DECODE;
					end
				end
				S_DECODE: begin
					walk_q <= 1'b0;
					// default: finish now with the present state
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
					case (cmd_q)
						ecah_pkg::CMD_NEXT: begin
							if (flags.cur_lt_high) begin
								state_q <= S_LOAD;
								busy_q  <= 1'b1;
								done_q  <= 1'b0;
							end else if (flags.at_limit) begin
								status_q <= ecah_pkg::STAT_LIMIT;
							end
						end
						ecah_pkg::CMD_SEEK: begin
							if (flags.tgt_out) begin
								status_q <= ecah_pkg::STAT_RANGE;
							end else if (flags.tgt_le_high) begin
								state_q <= S_LOAD;
								busy_q  <= 1'b1;
								done_q  <= 1'b0;
							end else begin
								state_q <= S_WALK;
								busy_q  <= 1'b1;
								done_q  <= 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
				S_WALK: begin
					// step until the target generation is current
					if (!flags.cur_lt_tgt) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
						done_q  <= 1'b1;
					end else if (flags.cur_lt_high) begin
						walk_q  <= 1'b1;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (walk_q) begin
						state_q <= S_WALK;
					end else begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
						done_q  <= 1'b1;
					end
				end
			endcase
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign status = status_q;

endmodule

`default_nettype wire

FILE: tb/ecah_row_checker.sv
// generation predictor and result checker for the elementary ca history engine
// watches the command, result and config channels; depends on ecah_pkg only
`timescale 1ns / 100ps

module ecah_row_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  command,
	input  logic [7:0]  target_generation,
	input  logic        done,
	input  logic [63:0] current_row,
	input  logic [7:0]  current_index,
	input  logic [7:0]  generated_count,
	input  logic [1:0]  status,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          errors,
	output int          pending
);

	localparam logic [63:0] LIVE_MASK = {64{1'b1}} >> (64 - ecah_pkg::CELLS);

	// one expected result beat
	typedef struct packed {
		logic [63:0] row;
		logic [7:0]  index;
		logic [7:0]  count;
		logic [1:0]  stat;
	} gen_report_t;

	// shadow copy of the configuration registers
	logic [7:0]  rule_bits;
	logic [8:0]  depth_limit;
	logic [63:0] seed_pattern;
	logic        seed_center;

	// shadow copy of the automaton and its history
	logic [63:0] row_now;
	logic [63:0] history [ecah_pkg::DEPTH];
	int          gen_now;
	int          gen_high;

	gen_report_t reports_due[$];
	int          error_tally = 0;

	// generations the history may hold
	function automatic int usable_depth();
		int d;
		d = int'(depth_limit);
		if (d == 0)
			d = 1;
		if (d > int'(ecah_pkg::DEPTH_CAP))
			d = int'(ecah_pkg::DEPTH_CAP);
		return d;
	endfunction

	// one generation of the rule on the ring
	function automatic logic [63:0] evolve_row(logic [63:0] cells);
		logic [63:0] nxt;
		logic [2:0]  hood;
		int          l;
		int          r;
		nxt = '0;
		for (int i = 0; i < ecah_pkg::CELLS; i++) begin
			l = (i == 0) ? ecah_pkg::CELLS - 1 : i - 1;
			r = (i == ecah_pkg::CELLS - 1) ? 0 : i + 1;
			hood = {cells[l], cells[i], cells[r]};
			nxt[i] = rule_bits[hood];
		end
		return nxt & LIVE_MASK;
	endfunction

	// replay the following stored generation or compute a new one
	function automatic logic [1:0] step_forward();
		if (gen_now < gen_high) begin
			gen_now++;
			row_now = history[gen_now % ecah_pkg::DEPTH];
			return ecah_pkg::STAT_OK;
		end
		if (gen_now + 1 >= usable_depth())
			return ecah_pkg::STAT_LIMIT;
		row_now = evolve_row(row_now);
		gen_now++;
		gen_high = gen_now;
		history[gen_now % ecah_pkg::DEPTH] = row_now;
		return ecah_pkg::STAT_OK;
	endfunction

	// apply one command beat and return the result it must produce
	function automatic gen_report_t predict_report(logic [1:0] op, logic [7:0] tgt);
		gen_report_t rep;
		logic [1:0]  st;
		st = ecah_pkg::STAT_OK;
		case (op)
			ecah_pkg::CMD_RESTART: begin
				row_now = seed_center ? (64'd1 << (ecah_pkg::CELLS / 2 % 64)) : seed_pattern;
				row_now &= LIVE_MASK;
				gen_now = 0;
				gen_high = 0;
				history[0] = row_now;
			end
			ecah_pkg::CMD_NEXT: begin
				st = step_forward();
			end
			ecah_pkg::CMD_SEEK: begin
				if (int'(tgt) >= usable_depth()) begin
					st = ecah_pkg::STAT_RANGE;
				end else if (int'(tgt) <= gen_high) begin
					gen_now = int'(tgt);
					row_now = history[gen_now % ecah_pkg::DEPTH];
				end else begin
					// walk forward, replaying first and then generating
					while (gen_now < int'(tgt)) begin
						if (step_forward() != ecah_pkg::STAT_OK)
							break;
					end
				end
			end
			default: begin
				// unknown command leaves everything as it is
			end
		endcase
		rep.row = row_now & LIVE_MASK;
		rep.index = 8'(gen_now);
		rep.count = 8'(gen_high);
		rep.stat = st;
		return rep;
	endfunction

	// count and print a wrong field
	function automatic void report_miss(string what, logic [63:0] exp_v, logic [63:0] got_v);
		error_tally++;
		$display("%0t: %s expected %h actual %h", $time, what, exp_v, got_v);
	endfunction

	// config writes, result compare and command prediction
	always @(posedge clk or negedge arst_n) begin
		gen_report_t want;
		if (!arst_n) begin
			rule_bits = 8'd30;
			depth_limit = 9'd256;
			seed_pattern = '0;
			seed_center = 1'b1;
			row_now = '0;
			gen_now = 0;
			gen_high = 0;
			reports_due.delete();
		end else begin
			if (cfg_write === 1'b1) begin
				case (cfg_index)
					ecah_pkg::REG_RULE:   rule_bits = cfg_data[7:0];
					ecah_pkg::REG_DEPTH:  depth_limit = cfg_data[8:0];
					ecah_pkg::REG_START:  seed_pattern = cfg_data;
					ecah_pkg::REG_CENTER: seed_center = cfg_data[0];
					default: ;
				endcase
			end

			// result beat against the oldest expectation
			if (done === 1'b1) begin
				if (reports_due.size() == 0) begin
					error_tally++;
					$display("%0t: result beat expected none actual row %h index %0d",
						$time, current_row, current_index);
				end else begin
					want = reports_due.pop_front();
					if (current_row !== want.row)
						report_miss("current_row", want.row, current_row);
					if (current_index !== want.index)
						report_miss("current_index", 64'(want.index), 64'(current_index));
					if (generated_count !== want.count)
						report_miss("generated_count", 64'(want.count), 64'(generated_count));
					if (status !== want.stat)
						report_miss("status", 64'(want.stat), 64'(status));
				end
			end

			// accepted command beat
			if (start === 1'b1 && busy === 1'b0) begin
				want = predict_report(command, target_generation);
				reports_due = {reports_due, want};
			end
		end
		errors <= error_tally;
		pending <= reports_due.size();
	end

endmodule

FILE: tb/elementary_ca_history_engine_test.sv
// stimulus, watchdog and verdict for the elementary ca history engine
// depends on ecah_pkg, the engine rtl and ecah_row_checker
`timescale 1ns / 100ps

module elementary_ca_history_engine_test;

	localparam logic [1:0] CMD_UNKNOWN = 2'd3;
	localparam int QUIET_LIMIT = 5000;
	localparam int PHASES = 8;
	localparam int PHASE_BEATS = 85;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  command = ecah_pkg::CMD_RESTART;
	logic [7:0]  target_generation = '0;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_index = ecah_pkg::REG_RULE;
	logic [63:0] cfg_data = '0;
	logic        busy;
	logic        done;
	logic [63:0] current_row;
	logic [7:0]  current_index;
	logic [7:0]  generated_count;
	logic [1:0]  status;
	int          errors;
	int          pending;

	bit idle_on = 1'b1;
	int quiet_cycles = 0;
	int live_depth = 256;   // usable history depth, only to aim seek targets

	elementary_ca_history_engine uut (.*);

	ecah_row_checker row_check (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	// nothing accepted for too long means the block hung
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1 || cfg_write === 1'b1) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// present one command beat and hold it until accepted
	task automatic send_beat(logic [1:0] op, logic [7:0] tgt);
		while (idle_on && $urandom_range(99) < 22) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		command <= op;
		target_generation <= tgt;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy !== 1'b0);
	endtask

	// write all four registers, junk in the unused upper data bits
	task automatic set_config(logic [7:0] rule, logic [8:0] depth, logic [63:0] pattern,
			logic center);
		logic [63:0] val;
		for (int k = 0; k < 4; k++) begin
			val = {$urandom, $urandom};
			case (ecah_pkg::cfg_reg_t'(k))
				ecah_pkg::REG_RULE:   val[7:0] = rule;
				ecah_pkg::REG_DEPTH:  val[8:0] = depth;
				ecah_pkg::REG_START:  val = pattern;
				ecah_pkg::REG_CENTER: val[0] = center;
				default: ;
			endcase
			cfg_write <= 1'b1;
			cfg_index <= ecah_pkg::cfg_reg_t'(k);
			cfg_data <= val;
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		live_depth = (depth == 0) ? 1 : (depth > 256) ? 256 : int'(depth);
	endtask

	// seek targets: mostly inside the history, some at its end or past it
	function automatic logic [7:0] pick_target();
		int roll;
		roll = $urandom_range(99);
		if (roll < 20)
			return 8'($urandom_range(255));
		if (roll < 32 && live_depth < 256)
			return 8'($urandom_range(255, live_depth));
		if (roll < 45)
			return 8'(live_depth - 1);
		return 8'($urandom_range(live_depth - 1));
	endfunction

	task automatic random_beat();
		int roll;
		roll = $urandom_range(99);
		if (roll < 7)
			send_beat(ecah_pkg::CMD_RESTART, 8'($urandom));
		else if (roll < 52)
			send_beat(ecah_pkg::CMD_NEXT, 8'($urandom));
		else if (roll < 96)
			send_beat(ecah_pkg::CMD_SEEK, pick_target());
		else
			send_beat(CMD_UNKNOWN, 8'($urandom));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: next before any restart, replay, generate to the end
		send_beat(ecah_pkg::CMD_NEXT, 8'h00);
		send_beat(ecah_pkg::CMD_SEEK, 8'd1);
		send_beat(ecah_pkg::CMD_RESTART, 8'hff);
		send_beat(ecah_pkg::CMD_NEXT, 8'h00);
		send_beat(ecah_pkg::CMD_NEXT, 8'h00);
		send_beat(ecah_pkg::CMD_NEXT, 8'h00);
		send_beat(ecah_pkg::CMD_SEEK, 8'd1);
		send_beat(ecah_pkg::CMD_NEXT, 8'h00);
		send_beat(ecah_pkg::CMD_SEEK, 8'd3);
		send_beat(ecah_pkg::CMD_SEEK, 8'd255);
		send_beat(ecah_pkg::CMD_NEXT, 8'h00);
		send_beat(ecah_pkg::CMD_SEEK, 8'd0);
		send_beat(ecah_pkg::CMD_NEXT, 8'h00);
		send_beat(CMD_UNKNOWN, 8'hff);
		send_beat(ecah_pkg::CMD_RESTART, 8'h00);

		// shallow history with a start pattern: limit and out of range seeks
		drain();
		set_config(8'd45, 9'd5, 64'ha5a5_0f0f_3c3c_f00f, 1'b0);
		send_beat(ecah_pkg::CMD_RESTART, 8'h00);
		send_beat(ecah_pkg::CMD_SEEK, 8'd4);
		send_beat(ecah_pkg::CMD_NEXT, 8'h00);
		send_beat(ecah_pkg::CMD_SEEK, 8'd5);
		send_beat(ecah_pkg::CMD_SEEK, 8'd255);
		send_beat(ecah_pkg::CMD_SEEK, 8'd0);
		send_beat(ecah_pkg::CMD_SEEK, 8'd2);
		send_beat(CMD_UNKNOWN, 8'h00);
		send_beat(ecah_pkg::CMD_NEXT, 8'h00);

		// random phases, each under its own register settings
		for (int p = 0; p < PHASES; p++) begin
			drain();
			repeat ($urandom_range(3)) @(posedge clk);
			case (p)
				0: set_config(8'd30, 9'd256, {$urandom, $urandom}, 1'b1);
				1: set_config(8'd110, 9'd0, {$urandom, $urandom}, 1'b0);
				2: set_config(8'd90, 9'd16, {64{1'b1}}, 1'b0);
				3: set_config(8'd0, 9'd511, {$urandom, $urandom}, 1'b0);
				4: set_config(8'd255, 9'd2, 64'h0, 1'b0);
				5: set_config(8'd150, 9'd255, 64'h8000_0000_0000_0001, 1'b0);
				default: set_config(8'($urandom), 9'($urandom_range(256, 1)),
					{$urandom, $urandom}, 1'($urandom));
			endcase
			// one phase runs back to back with no idle cycles
			idle_on = (p != 2);
			send_beat(ecah_pkg::CMD_RESTART, 8'($urandom));
			for (int n = 1; n < PHASE_BEATS; n++)
				random_beat();
		end
		idle_on = 1'b1;

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
